@@ rtl/bdte_pkg.sv @@
// Package for the broken-down time to epoch seconds converter.
// Holds the widths, the calendar tables, the state and command types and the parameter defaults.
// No dependencies.
package bdte_pkg;

	localparam int DEF_EPOCH_YEAR = 1970;
	localparam int DEF_MAX_YEAR   = 2199;
	localparam int BASE_YEAR      = 1900;

	localparam int FIELD_W = 32;
	localparam int IN_W    = 192;
	localparam int OUT_W   = 88;
	localparam int YEAR_W  = 12;
	localparam int DAY_W   = 20;
	localparam int DIV_W   = 31;
	localparam int DIVR_W  = 6;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_YCHK,
		ST_DBY_A,
		ST_DBY_B,
		ST_OFS,
		ST_DAYS,
		ST_DCHK,
		ST_YWALK,
		ST_MWALK,
		ST_WD_A,
		ST_WD_B,
		ST_ES_A,
		ST_ES_B,
		ST_FIN_OK,
		ST_FIN_BAD
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_DIV_START,
		OP_DIV_FINISH,
		OP_DBY_A,
		OP_DBY_B,
		OP_OFS,
		OP_DAYS,
		OP_YWALK,
		OP_MWALK,
		OP_WD_A,
		OP_WD_B,
		OP_ES_A,
		OP_ES_B,
		OP_OUT_OK,
		OP_OUT_BAD
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] k;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic carry_ok;
		logic year_ok;
		logic d_ok;
		logic year_more;
		logic month_more;
	} sts_t;

	localparam logic [1:0] K_SEC  = 2'd0;
	localparam logic [1:0] K_MIN  = 2'd1;
	localparam logic [1:0] K_HOUR = 2'd2;
	localparam logic [1:0] K_MON  = 2'd3;

	function automatic logic [DIVR_W-1:0] carry_div(input logic [1:0] k);
		logic [DIVR_W-1:0] d;
		case (k)
			K_SEC:   d = 6'd60;
			K_MIN:   d = 6'd60;
			K_HOUR:  d = 6'd24;
			default: d = 6'd12;
		endcase
		return d;
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m);
		logic [4:0] n;
		case (m)
			4'd1:    n = 5'd28;
			4'd3:    n = 5'd30;
			4'd5:    n = 5'd30;
			4'd8:    n = 5'd30;
			4'd10:   n = 5'd30;
			default: n = 5'd31;
		endcase
		return n;
	endfunction

	function automatic logic [8:0] cum_days(input logic [3:0] m);
		logic [8:0] n;
		case (m)
			4'd0:    n = 9'd0;
			4'd1:    n = 9'd31;
			4'd2:    n = 9'd59;
			4'd3:    n = 9'd90;
			4'd4:    n = 9'd120;
			4'd5:    n = 9'd151;
			4'd6:    n = 9'd181;
			4'd7:    n = 9'd212;
			4'd8:    n = 9'd243;
			4'd9:    n = 9'd273;
			4'd10:   n = 9'd304;
			default: n = 9'd334;
		endcase
		return n;
	endfunction

endpackage

@@ rtl/broken_down_time_to_epoch.sv @@
// Top level of the broken-down time to epoch seconds converter.
// Joins bdte_ctrl and bdte_dp; uses bdte_pkg.
//
//   channel   dir   width  beat contents
//   s_axis    in    192    second, minute, hour, day_of_month, month, years_since_1900
//   m_axis    out   88     valid_res, epoch_seconds, normalized fields, weekday, day_of_year
//
// One item at a time; the beat is taken in the idle state. Four field carries run in the
// reciprocal divider, then checks and offsets, up to MAX_YEAR-EPOCH_YEAR year steps plus
// one, up to 12 month steps, weekday and seconds, and a handoff; a rejected item skips
// the rest once a carry or range check fails.
// A finished result waits in the output register while the next beat is taken.
// arst_n clears control state only; no clearing pass.
module broken_down_time_to_epoch #(
	parameter int EPOCH_YEAR = bdte_pkg::DEF_EPOCH_YEAR,
	parameter int MAX_YEAR   = bdte_pkg::DEF_MAX_YEAR
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// second, minute, hour, day_of_month, month, years_since_1900 (32 bits each)
	input  logic [bdte_pkg::IN_W-1:0]   s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// valid_res, epoch_seconds, norm_second, norm_minute, norm_hour, norm_day,
	// norm_month, norm_year, weekday, day_of_year, zero pad
	output logic [bdte_pkg::OUT_W-1:0]  m_tdata
);

	bdte_pkg::cmd_t cmd;
	bdte_pkg::sts_t sts;

	bdte_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bdte_dp #(
		.EPOCH_YEAR (EPOCH_YEAR),
		.MAX_YEAR   (MAX_YEAR)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_data  (s_tdata),
		.sts      (sts),
		.out_data (m_tdata)
	);

endmodule

@@ rtl/bdte_div.sv @@
// Reciprocal divider for the field carries: shift out the power of two, multiply by
// a fixed reciprocal of 15 or 3, shift the product, then form the remainder.
// Uses bdte_pkg for widths and the carry selector.
module bdte_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [bdte_pkg::DIV_W-1:0]     dividend,
	input  logic [1:0]                     k,
	output logic                           done,
	output logic [bdte_pkg::DIV_W-1:0]     quo,
	output logic [bdte_pkg::DIVR_W-1:0]    rem
);

	localparam int QD_W = 2 * bdte_pkg::DIVR_W;

	logic                           vld_s1;
	logic                           vld_s2;
	logic                           done_q;
	logic [bdte_pkg::DIV_W-1:0]     n_q;
	logic [1:0]                     k_q;
	logic                           by3_q;
	logic [31:0]                    pre_q;
	logic [63:0]                    prod_s2;
	logic [bdte_pkg::DIV_W-1:0]     quo_q;
	logic [31:0]                    recip;
	logic [bdte_pkg::DIV_W-1:0]     qpost;
	logic [bdte_pkg::DIVR_W-1:0]    dvs;
	logic [QD_W-1:0]                qd;

	assign recip = by3_q ? 32'hAAAAAAAB : 32'h88888889;
	assign qpost = by3_q ? bdte_pkg::DIV_W'(prod_s2 >> 33) : bdte_pkg::DIV_W'(prod_s2 >> 35);
	assign dvs   = bdte_pkg::carry_div(k_q);
	assign qd    = QD_W'(quo_q[bdte_pkg::DIVR_W-1:0]) * QD_W'(dvs);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			done_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= dividend;
			k_q <= k;
			case (k)
				bdte_pkg::K_HOUR: begin
					by3_q <= 1'b1;
					pre_q <= 32'(dividend >> 3);
				end
				bdte_pkg::K_MON: begin
					by3_q <= 1'b1;
					pre_q <= 32'(dividend >> 2);
				end
				default: begin
					by3_q <= 1'b0;
					pre_q <= 32'(dividend >> 2);
				end
			endcase
		end
		if (vld_s1) begin
			prod_s2 <= 64'(pre_q) * 64'(recip);
		end
		if (vld_s2) begin
			quo_q <= qpost;
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = n_q[bdte_pkg::DIVR_W-1:0] - qd[bdte_pkg::DIVR_W-1:0];

endmodule

@@ rtl/bdte_dp.sv @@
// Datapath: field registers, carries, day count, year and month walk, weekday, seconds.
// Uses bdte_pkg and bdte_div.
module bdte_dp #(
	parameter int EPOCH_YEAR = bdte_pkg::DEF_EPOCH_YEAR,
	parameter int MAX_YEAR   = bdte_pkg::DEF_MAX_YEAR
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bdte_pkg::cmd_t              cmd,
	input  logic [bdte_pkg::IN_W-1:0]   in_data,
	output bdte_pkg::sts_t              sts,
	output logic [bdte_pkg::OUT_W-1:0]  out_data
);

	localparam int EP1  = EPOCH_YEAR - 1;
	localparam int DBE  = 365 * EP1 + EP1 / 4 - EP1 / 100 + EP1 / 400;
	localparam int MX   = MAX_YEAR;
	localparam int DBM  = 365 * MX + MX / 4 - MX / 100 + MX / 400;
	localparam int DMAX = DBM - DBE - 1;
	localparam int WK   = (DBE + 1) % 7;
	localparam int C400 = EPOCH_YEAR % 400;
	localparam int RECIP7 = 1198373;

	localparam int YW = bdte_pkg::YEAR_W;
	localparam int DW = bdte_pkg::DAY_W;

	logic signed [31:0] sec_q, min_q, hr_q, day_q, mon_q, yr_q;
	logic signed [31:0] x, nxt;
	logic [bdte_pkg::DIVR_W-1:0] dvs;
	logic                         div_done;
	logic [bdte_pkg::DIV_W-1:0]   quo;
	logic [bdte_pkg::DIVR_W-1:0]  rem;
	logic [31:0]                  q32;
	logic [bdte_pkg::DIVR_W-1:0]  r6;
	logic [32:0]                  sum33;
	logic signed [32:0]           yfull;
	logic [YW-1:0]                yv, pv;
	logic [24:0]                  pprod_q, yprod_q;
	logic [20:0]                  dby_q;
	logic [5:0]                   p100, y100;
	logic [20:0]                  dby;
	logic [YW-1:0]                r100;
	logic                         leapy;
	logic [8:0]                   cum;
	logic [DW-1:0]                yoff_q;
	logic [21:0]                  yoff_n;
	logic signed [33:0]           d_q;
	logic signed [33:0]           dsum;
	logic [DW-1:0]                rem_q;
	logic [YW-1:0]                yc_q;
	logic [8:0]                   c400_q;
	logic [3:0]                   m_q;
	logic [8:0]                   yday_q;
	logic                         leapc;
	logic [8:0]                   ylen;
	logic [4:0]                   mlen;
	logic [DW-1:0]                t;
	logic [40:0]                  wprod_q;
	logic [DW-1:0]                wdiff;
	logic [2:0]                   wday_q;
	logic [36:0]                  eprod_q;
	logic [16:0]                  tod;
	logic [32:0]                  secs_q;
	logic [bdte_pkg::OUT_W-1:0]   out_q;
	logic [8:0]                   nyear;
	logic [4:0]                   nday;

	always_comb begin
		case (cmd.k)
			bdte_pkg::K_SEC: begin
				x   = sec_q;
				nxt = min_q;
			end
			bdte_pkg::K_MIN: begin
				x   = min_q;
				nxt = hr_q;
			end
			bdte_pkg::K_HOUR: begin
				x   = hr_q;
				nxt = day_q;
			end
			default: begin
				x   = mon_q;
				nxt = yr_q;
			end
		endcase
	end

	assign dvs = bdte_pkg::carry_div(cmd.k);

	bdte_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.op == bdte_pkg::OP_DIV_START),
		.dividend (x[31] ? ~x[30:0] : x[30:0]),
		.k        (cmd.k),
		.done     (div_done),
		.quo      (quo),
		.rem      (rem)
	);

	assign q32   = x[31] ? ~{1'b0, quo} : {1'b0, quo};
	assign r6    = x[31] ? (dvs - 6'd1 - rem) : rem;
	assign sum33 = {nxt[31], nxt} + {q32[31], q32};

	assign yfull = {yr_q[31], yr_q} + 33'sd1900;
	assign yv    = yfull[YW-1:0];
	assign pv    = yv - 1'b1;

	assign p100  = pprod_q[24:19];
	assign dby   = 21'(pv) * 21'd365 + 21'(pv >> 2) - 21'(p100) + 21'(p100 >> 2);
	assign y100  = yprod_q[24:19];
	assign r100  = yv - YW'(y100) * YW'(100);
	assign leapy = (yv[1:0] == 2'd0) && ((r100 != '0) || (y100[1:0] == 2'd0));
	assign cum   = bdte_pkg::cum_days(mon_q[3:0]) + 9'((mon_q[3:0] >= 4'd2) && leapy);
	assign yoff_n = 22'(dby_q) - 22'(DBE) + 22'(cum);
	assign dsum  = $signed({14'd0, yoff_q}) + $signed({{2{day_q[31]}}, day_q}) - 34'sd1;

	assign leapc = (c400_q[1:0] == 2'd0) &&
		!((c400_q == 9'd100) || (c400_q == 9'd200) || (c400_q == 9'd300));
	assign ylen  = leapc ? 9'd366 : 9'd365;
	assign mlen  = bdte_pkg::month_len(m_q) + 5'((m_q == 4'd1) && leapc);

	assign t     = d_q[DW-1:0] + DW'(WK);
	assign wdiff = t - DW'(wprod_q[40:23]) * DW'(7);
	assign tod   = 17'(hr_q[4:0]) * 17'd3600 + 17'(min_q[5:0]) * 17'd60 + 17'(sec_q[5:0]);

	assign nyear = 9'(yc_q - YW'(bdte_pkg::BASE_YEAR));
	assign nday  = rem_q[4:0] + 5'd1;

	assign sts.div_done   = div_done;
	assign sts.carry_ok   = sum33[32] == sum33[31];
	assign sts.year_ok    = (yfull >= 33'sd0 + 33'(EPOCH_YEAR)) && (yfull <= 33'sd0 + 33'(MAX_YEAR));
	assign sts.d_ok       = !d_q[33] && (d_q <= 34'sd0 + 34'(DMAX));
	assign sts.year_more  = rem_q >= DW'(ylen);
	assign sts.month_more = rem_q >= DW'(mlen);

	always_ff @(posedge clk) begin
		case (cmd.op)
			bdte_pkg::OP_LOAD: begin
				sec_q <= in_data[31:0];
				min_q <= in_data[63:32];
				hr_q  <= in_data[95:64];
				day_q <= in_data[127:96];
				mon_q <= in_data[159:128];
				yr_q  <= in_data[191:160];
			end
			bdte_pkg::OP_DIV_FINISH: begin
				case (cmd.k)
					bdte_pkg::K_SEC: begin
						sec_q <= 32'(r6);
						min_q <= sum33[31:0];
					end
					bdte_pkg::K_MIN: begin
						min_q <= 32'(r6);
						hr_q  <= sum33[31:0];
					end
					bdte_pkg::K_HOUR: begin
						hr_q  <= 32'(r6);
						day_q <= sum33[31:0];
					end
					default: begin
						mon_q <= 32'(r6);
						yr_q  <= sum33[31:0];
					end
				endcase
			end
			bdte_pkg::OP_DBY_A: begin
				pprod_q <= 25'(pv) * 25'd5243;
			end
			bdte_pkg::OP_DBY_B: begin
				dby_q   <= dby;
				yprod_q <= 25'(yv) * 25'd5243;
			end
			bdte_pkg::OP_OFS: begin
				yoff_q <= yoff_n[DW-1:0];
			end
			bdte_pkg::OP_DAYS: begin
				d_q    <= dsum;
				rem_q  <= dsum[DW-1:0];
				yc_q   <= YW'(EPOCH_YEAR);
				c400_q <= 9'(C400);
				m_q    <= '0;
			end
			bdte_pkg::OP_YWALK: begin
				if (rem_q >= DW'(ylen)) begin
					rem_q  <= rem_q - DW'(ylen);
					yc_q   <= yc_q + 1'b1;
					c400_q <= (c400_q == 9'd399) ? 9'd0 : c400_q + 9'd1;
				end else begin
					yday_q <= rem_q[8:0];
				end
			end
			bdte_pkg::OP_MWALK: begin
				if (rem_q >= DW'(mlen)) begin
					rem_q <= rem_q - DW'(mlen);
					m_q   <= m_q + 1'b1;
				end
			end
			bdte_pkg::OP_WD_A: begin
				wprod_q <= 41'(t) * 41'(RECIP7);
			end
			bdte_pkg::OP_WD_B: begin
				wday_q <= wdiff[2:0];
			end
			bdte_pkg::OP_ES_A: begin
				eprod_q <= 37'(d_q[DW-1:0]) * 37'd86400;
			end
			bdte_pkg::OP_ES_B: begin
				secs_q <= eprod_q[32:0] + 33'(tod);
			end
			bdte_pkg::OP_OUT_OK: begin
				out_q <= {7'd0, yday_q, wday_q, nyear, m_q, nday, hr_q[4:0],
					min_q[5:0], sec_q[5:0], secs_q, 1'b1};
			end
			bdte_pkg::OP_OUT_BAD: begin
				out_q <= '0;
			end
			default: begin
			end
		endcase
	end

	assign out_data = out_q;

endmodule

@@ rtl/bdte_ctrl.sv @@
// Controller: sequences carries, range checks, calendar walk and output handoff.
// Uses bdte_pkg types; drives the datapath through cmd_t and reads sts_t.
module bdte_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	output logic            m_tvalid,
	input  logic            m_tready,
	input  bdte_pkg::sts_t  sts,
	output bdte_pkg::cmd_t  cmd
);

	bdte_pkg::state_t state_q, state_n;
	logic [1:0]       k_q;
	logic             m_tvalid_q;
	logic             slot_free;

	assign slot_free = !m_tvalid_q || m_tready;

	always_comb begin
		state_n = state_q;
		case (state_q)
			bdte_pkg::ST_IDLE:     if (s_tvalid) state_n = bdte_pkg::ST_DIV_GO;
			bdte_pkg::ST_DIV_GO:   state_n = bdte_pkg::ST_DIV_WAIT;
			bdte_pkg::ST_DIV_WAIT: begin
				if (sts.div_done) begin
					if (!sts.carry_ok) state_n = bdte_pkg::ST_FIN_BAD;
					else if (k_q == bdte_pkg::K_MON) state_n = bdte_pkg::ST_YCHK;
					else state_n = bdte_pkg::ST_DIV_GO;
				end
			end
			bdte_pkg::ST_YCHK:
				state_n = sts.year_ok ? bdte_pkg::ST_DBY_A : bdte_pkg::ST_FIN_BAD;
			bdte_pkg::ST_DBY_A:    state_n = bdte_pkg::ST_DBY_B;
			bdte_pkg::ST_DBY_B:    state_n = bdte_pkg::ST_OFS;
			bdte_pkg::ST_OFS:      state_n = bdte_pkg::ST_DAYS;
			bdte_pkg::ST_DAYS:     state_n = bdte_pkg::ST_DCHK;
			bdte_pkg::ST_DCHK:
				state_n = sts.d_ok ? bdte_pkg::ST_YWALK : bdte_pkg::ST_FIN_BAD;
			bdte_pkg::ST_YWALK:    if (!sts.year_more) state_n = bdte_pkg::ST_MWALK;
			bdte_pkg::ST_MWALK:    if (!sts.month_more) state_n = bdte_pkg::ST_WD_A;
			bdte_pkg::ST_WD_A:     state_n = bdte_pkg::ST_WD_B;
			bdte_pkg::ST_WD_B:     state_n = bdte_pkg::ST_ES_A;
			bdte_pkg::ST_ES_A:     state_n = bdte_pkg::ST_ES_B;
			bdte_pkg::ST_ES_B:     state_n = bdte_pkg::ST_FIN_OK;
			bdte_pkg::ST_FIN_OK:   if (slot_free) state_n = bdte_pkg::ST_IDLE;
			bdte_pkg::ST_FIN_BAD:  if (slot_free) state_n = bdte_pkg::ST_IDLE;
			default:               state_n = bdte_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.op   = bdte_pkg::OP_NONE;
		cmd.k    = k_q;
		s_tready = 1'b0;
		case (state_q)
			bdte_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) cmd.op = bdte_pkg::OP_LOAD;
			end
			bdte_pkg::ST_DIV_GO:   cmd.op = bdte_pkg::OP_DIV_START;
			bdte_pkg::ST_DIV_WAIT: if (sts.div_done) cmd.op = bdte_pkg::OP_DIV_FINISH;
			bdte_pkg::ST_DBY_A:    cmd.op = bdte_pkg::OP_DBY_A;
			bdte_pkg::ST_DBY_B:    cmd.op = bdte_pkg::OP_DBY_B;
			bdte_pkg::ST_OFS:      cmd.op = bdte_pkg::OP_OFS;
			bdte_pkg::ST_DAYS:     cmd.op = bdte_pkg::OP_DAYS;
			bdte_pkg::ST_YWALK:    cmd.op = bdte_pkg::OP_YWALK;
			bdte_pkg::ST_MWALK:    cmd.op = bdte_pkg::OP_MWALK;
			bdte_pkg::ST_WD_A:     cmd.op = bdte_pkg::OP_WD_A;
			bdte_pkg::ST_WD_B:     cmd.op = bdte_pkg::OP_WD_B;
			bdte_pkg::ST_ES_A:     cmd.op = bdte_pkg::OP_ES_A;
			bdte_pkg::ST_ES_B:     cmd.op = bdte_pkg::OP_ES_B;
			bdte_pkg::ST_FIN_OK:   if (slot_free) cmd.op = bdte_pkg::OP_OUT_OK;
			bdte_pkg::ST_FIN_BAD:  if (slot_free) cmd.op = bdte_pkg::OP_OUT_BAD;
			default:               cmd.op = bdte_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= bdte_pkg::ST_IDLE;
			k_q        <= bdte_pkg::K_SEC;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_q == bdte_pkg::ST_IDLE) begin
				k_q <= bdte_pkg::K_SEC;
			end else if (state_q == bdte_pkg::ST_DIV_WAIT && sts.div_done) begin
				k_q <= k_q + 1'b1;
			end
			if ((cmd.op == bdte_pkg::OP_OUT_OK) || (cmd.op == bdte_pkg::OP_OUT_BAD)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;

endmodule
